// ===== design/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN transmit segment queue package
// Shared sizes, request codes, register indexes and the slot entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

  // Ring depth and the index width that follows from it.
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Field widths of one frame.
  localparam int unsigned ID_W     = 11;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned MSGLEN_W = 6;
  localparam int unsigned WORDS    = 4;
  localparam int unsigned WCNT_W   = 3;

  // Longest segmented message in bytes.
  localparam logic [MSGLEN_W-1:0] MAX_SEG_BYTES = MSGLEN_W'(32);
  localparam logic [LEN_W-1:0]    FULL_LEN      = LEN_W'(8);

  // Request codes.
  localparam logic [1:0] REQ_SEGMENTED = 2'd0;
  localparam logic [1:0] REQ_SINGLE    = 2'd1;
  localparam logic [1:0] REQ_TX_DONE   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned REG_IDX_W    = 2;
  localparam logic [REG_IDX_W-1:0] REG_SEG_ID    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SINGLE_ID = REG_IDX_W'(1);

  // Register reset values.
  localparam logic [ID_W-1:0] SEG_ID_RESET    = ID_W'(158);
  localparam logic [ID_W-1:0] SINGLE_ID_RESET = ID_W'(398);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  // One ring slot.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ID_W-1:0]   ident;
    logic [DATA_W-1:0] data;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Ring index increment with wrap at the queue depth.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == LAST_IDX) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== design/can_tx_segment_queue_unit.sv =====
// ----------------------------------------------------------------------------
// CAN transmit segment queue
// Ring of frames awaiting transmission, filled by segmented and single
// requests and drained one frame per load toward the transmitter.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive as beats on the input channel (valid/ready). A segmented
// request of up to 32 bytes is cut into 8-byte frames, a single request
// queues one frame, and a transmit-done event pulls the next frame if one
// is queued. Frames are held in a slot RAM with one write and one read port.
// Whenever a frame is handed to the transmitter it leaves as one beat on the
// output channel; no other request produces an output beat.
// Timing: the block takes one request at a time. A request is captured,
// then writes its frames one after another (zero to four, one RAM write
// port), then, if it loads a frame, reads the RAM and registers the
// result; a result not yet taken by the receiver can hold it there.
// Configuration writes take effect on the next edge.
// Reset empties the ring (both indexes zero), marks the transmitter free and
// restores the identifier registers; the slot contents stay undefined.
// A stalled receiver does not stop intake: the result sits in the output
// register and the next request is processed, waiting only before it would
// overwrite a result that has not yet been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module can_tx_segment_queue_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [cts_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cts_pkg::ID_W-1:0]        cfg_wdata_i,
  // Request channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [cts_pkg::MSGLEN_W-1:0]    msg_len_i,
  input  wire logic [cts_pkg::DATA_W-1:0]      payload_w0_i,
  input  wire logic [cts_pkg::DATA_W-1:0]      payload_w1_i,
  input  wire logic [cts_pkg::DATA_W-1:0]      payload_w2_i,
  input  wire logic [cts_pkg::DATA_W-1:0]      payload_w3_i,
  // Loaded frame channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [cts_pkg::LEN_W-1:0]            frame_len_o,
  output logic [cts_pkg::ID_W-1:0]             frame_ident_o,
  output logic [31:0]                          frame_data_a_o,
  output logic [31:0]                          frame_data_b_o
);

  import cts_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;

  // Queue control state.
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             tx_free_q, tx_free_d;

  // Identifier registers.
  logic [ID_W-1:0] seg_id_q;
  logic [ID_W-1:0] single_id_q;

  // Captured request: payload words shift down one word per frame written.
  logic [DATA_W-1:0] pay_q [WORDS];
  logic [WCNT_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0]  last_len_q;
  logic [ID_W-1:0]   ident_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [LEN_W-1:0]  out_len_q;
  logic [ID_W-1:0]   out_ident_q;
  logic [DATA_W-1:0] out_data_q;

  logic in_fire;
  logic out_free;
  logic capture;

  // Decode of the incoming request.
  logic [MSGLEN_W:0]  len_plus;
  logic [WCNT_W-1:0]  seg_count;
  logic [LEN_W-1:0]   seg_last_len;
  logic               seg_ok;

  // RAM ports.
  logic              ram_we;
  logic              ram_re;
  slot_t             wr_slot;
  slot_t             rd_slot;
  logic [SLOT_W-1:0] ram_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Frame count of a segmented message: an empty message still makes one frame.
  assign len_plus  = {1'b0, msg_len_i} + (MSGLEN_W + 1)'(7);
  assign seg_count = (msg_len_i == '0) ? WCNT_W'(1) : WCNT_W'(len_plus >> 3);
  assign seg_ok    = (msg_len_i <= MAX_SEG_BYTES);

  // Length code of the last frame: zero for an empty message, the remainder,
  // or a full frame when the message length is a nonzero multiple of eight.
  always_comb begin
    if (msg_len_i == '0) begin
      seg_last_len = '0;
    end else if (msg_len_i[2:0] == 3'd0) begin
      seg_last_len = FULL_LEN;
    end else begin
      seg_last_len = LEN_W'(msg_len_i[2:0]);
    end
  end

  // The slot being written takes the next payload word; only the last frame
  // of a message carries the short length.
  always_comb begin
    wr_slot.ident = ident_q;
    wr_slot.data  = pay_q[0];
    wr_slot.len   = (rem_q == WCNT_W'(1)) ? last_len_q : FULL_LEN;
  end

  assign ram_we = (state_q == S_WRITE);
  assign ram_re = (state_q == S_READ);

  cts_slot_ram #(
    .WIDTH  (SLOT_W),
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  // Sequencer. The RAM read of a load follows every write of the request,
  // so the read never races a write to the same slot.
  always_comb begin
    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    tx_free_d   = tx_free_q;
    rem_d       = rem_q;
    capture     = 1'b0;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (req_type_i)
            REQ_TX_DONE: begin
              if (wr_idx_q != rd_idx_q) begin
                state_d = S_READ;
              end else begin
                tx_free_d = 1'b1;
              end
            end
            REQ_SEGMENTED: begin
              if (seg_ok) begin
                capture = 1'b1;
                rem_d   = seg_count;
                state_d = S_WRITE;
              end else if (tx_free_q && (wr_idx_q != rd_idx_q)) begin
                tx_free_d = 1'b0;
                state_d   = S_READ;
              end
            end
            REQ_SINGLE: begin
              capture = 1'b1;
              rem_d   = WCNT_W'(1);
              state_d = S_WRITE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WRITE: begin
        wr_idx_d = next_idx(wr_idx_q);
        rem_d    = rem_q - WCNT_W'(1);
        if (rem_q == WCNT_W'(1)) begin
          // Something was written, so a free transmitter always gets a frame.
          if (tx_free_q) begin
            tx_free_d = 1'b0;
            state_d   = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        rd_idx_d = next_idx(rd_idx_q);
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      tx_free_q   <= 1'b1;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      seg_id_q    <= SEG_ID_RESET;
      single_id_q <= SINGLE_ID_RESET;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      tx_free_q   <= tx_free_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SEG_ID:    seg_id_q    <= cfg_wdata_i;
          REG_SINGLE_ID: single_id_q <= cfg_wdata_i;
          default:       ;
        endcase
      end
    end
  end

  // Request capture and payload shift.
  always_ff @(posedge clk_i) begin
    if (capture) begin
      pay_q[0] <= payload_w0_i;
      pay_q[1] <= payload_w1_i;
      pay_q[2] <= payload_w2_i;
      pay_q[3] <= payload_w3_i;
      if (req_type_i == REQ_SINGLE) begin
        ident_q    <= single_id_q;
        last_len_q <= FULL_LEN;
      end else begin
        ident_q    <= seg_id_q;
        last_len_q <= seg_last_len;
      end
    end else if (state_q == S_WRITE) begin
      for (int i = 0; i < WORDS - 1; i++) begin
        pay_q[i] <= pay_q[i+1];
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_RESP) && out_free) begin
      out_len_q   <= rd_slot.len;
      out_ident_q <= rd_slot.ident;
      out_data_q  <= rd_slot.data;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_len_o    = out_len_q;
  assign frame_ident_o  = out_ident_q;
  assign frame_data_a_o = out_data_q[31:0];
  assign frame_data_b_o = out_data_q[63:32];

endmodule

`default_nettype wire

// ===== design/cts_slot_ram.sv =====
// ----------------------------------------------------------------------------
// CAN transmit segment queue slot RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cts_slot_ram #(
  parameter int unsigned WIDTH  = 79,
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
